// ----- rtl/sis_pkg.sv -----
// sis_pkg: shared types and constants for the sorted interval set
// used by sis_cell and sorted_interval_set_top; no dependencies
package sis_pkg;

	localparam int MAX_INTERVALS = 64;
	localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);

	// item kinds
	localparam logic [1:0] KIND_ADD   = 2'd0;
	localparam logic [1:0] KIND_QUERY = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	// status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_FULL     = 2'd1;
	localparam logic [1:0] STAT_REVERSED = 2'd2;

	// operation broadcast to the cell row
	typedef logic [2:0] cell_op_t;
	localparam cell_op_t OP_HOLD    = 3'd0;
	localparam cell_op_t OP_EVAL    = 3'd1;
	localparam cell_op_t OP_MERGE   = 3'd2;
	localparam cell_op_t OP_COMPACT = 3'd3;
	localparam cell_op_t OP_INSERT  = 3'd4;

	// what a cell shows its neighbors
	typedef struct packed {
		logic [31:0] lo;
		logic [31:0] hi;
		logic        joined; // entry overlaps or touches the item
		logic        tail;   // valid entry lying wholly above the item
		logic        after;  // tail or empty: at or past the insert slot
	} link_t;

endpackage

// ----- rtl/sis_cell.sv -----
// sis_cell: one slot of the interval row, holds one interval and its flags
// depends on sis_pkg; shifts data to and from its neighbors under the broadcast op
module sis_cell
	import sis_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cell_op_t    op,
	input  logic [31:0] cmd_lo,
	input  logic [31:0] cmd_hi,
	input  logic [31:0] cmd_pt,
	input  logic        valid,
	input  link_t       left,
	input  link_t       right,
	output link_t       link,
	output logic        hit,
	output logic        pair
);

	logic [31:0] low_q;
	logic [31:0] high_q;
	logic        join_q;
	logic        tail_q;
	logic        hit_q;

	logic join_d;
	logic overlap;
	logic touch_hi;
	logic touch_lo;
	logic first;
	logic shift_dn;
	logic after;

	assign overlap  = (low_q <= cmd_hi) && (cmd_lo <= high_q);
	assign touch_hi = (high_q != 32'hFFFF_FFFF) && (cmd_lo == high_q + 32'd1);
	assign touch_lo = (low_q != 32'd0) && (cmd_hi == low_q - 32'd1);
	assign join_d   = valid && (overlap || touch_hi || touch_lo);

	assign first    = join_q && !left.joined;
	assign shift_dn = (join_q && left.joined) || tail_q;
	assign after    = tail_q || !valid;

	always_ff @(posedge clk) begin
		unique case (op)
			OP_MERGE: begin
				if (first) begin
					low_q  <= (cmd_lo < low_q) ? cmd_lo : low_q;
					high_q <= (cmd_hi > high_q) ? cmd_hi : high_q;
				end
			end
			OP_COMPACT: begin
				if (first) begin
					high_q <= (right.hi > high_q) ? right.hi : high_q;
				end else if (shift_dn) begin
					low_q  <= right.lo;
					high_q <= right.hi;
				end
			end
			OP_INSERT: begin
				if (after && left.after) begin
					low_q  <= left.lo;
					high_q <= left.hi;
				end else if (after) begin
					low_q  <= cmd_lo;
					high_q <= cmd_hi;
				end
			end
			OP_HOLD, OP_EVAL: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			join_q <= 1'b0;
			tail_q <= 1'b0;
			hit_q  <= 1'b0;
		end else if (op == OP_EVAL) begin
			join_q <= join_d;
			tail_q <= valid && !join_d && (low_q > cmd_hi);
			hit_q  <= valid && (low_q <= cmd_pt) && (cmd_pt <= high_q);
		end else if (op == OP_COMPACT && shift_dn) begin
			// flags travel down with the entry
			join_q <= right.joined;
			tail_q <= right.tail;
		end
	end

	assign link.lo     = low_q;
	assign link.hi     = high_q;
	assign link.joined = join_q;
	assign link.tail   = tail_q;
	assign link.after  = after;
	assign hit         = hit_q;
	assign pair        = join_q && right.joined;

endmodule

// ----- rtl/sorted_interval_set_top.sv -----
// sorted_interval_set_top: sorted set of disjoint 32-bit intervals on a row of cells
// sequence: each accepted item steps through eval and act to the response step;
// an add that merges also runs compaction, one shift per absorbed entry leaving the row
// throughput: one item at a time, set by the row sequence and by output back-pressure
// reset: arst_n clears the count, the controller, the output valid and the cell flags; interval
// storage is not cleared and is never read past the count
module sorted_interval_set_top
	import sis_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [95:0]  s_axis_tdata,   // lower[31:0], upper[63:32], point[95:64]
	input  logic [1:0]   s_axis_tuser,   // kind[1:0]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [15:0]  m_axis_tdata    // found[0], status[2:1], interval_count[9:3]
);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_EVAL    = 3'd1;
	localparam logic [2:0] S_ACT     = 3'd2;
	localparam logic [2:0] S_COMPACT = 3'd3;
	localparam logic [2:0] S_RESP    = 3'd4;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic [1:0]       kind_q;
	logic [31:0]      lo_q;
	logic [31:0]      hi_q;
	logic [31:0]      pt_q;
	logic             found_q;
	logic [1:0]       status_q;
	logic             out_valid_q;
	logic [15:0]      out_data_q;

	cell_op_t                 cell_op;
	link_t                    links [MAX_INTERVALS];
	logic [MAX_INTERVALS-1:0] valid_vec;
	logic [MAX_INTERVALS-1:0] hit_vec;
	logic [MAX_INTERVALS-1:0] pair_vec;
	logic [MAX_INTERVALS-1:0] join_vec;

	logic any_join;
	logic any_hit;
	logic more;
	logic full;
	logic add_ok;
	logic out_free;

	genvar k;
	generate
		for (k = 0; k < MAX_INTERVALS; k++) begin : g_row
			link_t left_l;
			link_t right_l;
			if (k == 0) begin : g_first
				assign left_l = '0;
			end else begin : g_mid_l
				assign left_l = links[k-1];
			end
			if (k == MAX_INTERVALS - 1) begin : g_last
				assign right_l = '0;
			end else begin : g_mid_r
				assign right_l = links[k+1];
			end
			assign valid_vec[k] = count_q > CNT_W'(k);
			assign join_vec[k]  = links[k].joined;

			sis_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.op     (cell_op),
				.cmd_lo (lo_q),
				.cmd_hi (hi_q),
				.cmd_pt (pt_q),
				.valid  (valid_vec[k]),
				.left   (left_l),
				.right  (right_l),
				.link   (links[k]),
				.hit    (hit_vec[k]),
				.pair   (pair_vec[k])
			);
		end
	endgenerate

	assign any_join = |join_vec;
	assign any_hit  = |hit_vec;
	assign more     = |pair_vec;
	assign full     = count_q == CNT_W'(MAX_INTERVALS);
	assign add_ok   = (kind_q == KIND_ADD) && (lo_q <= hi_q);
	assign out_free = !out_valid_q || m_axis_tready;

	always_comb begin
		cell_op = OP_HOLD;
		unique case (state_q)
			S_EVAL: cell_op = OP_EVAL;
			S_ACT: begin
				if (add_ok && any_join) begin
					cell_op = OP_MERGE;
				end else if (add_ok && !full) begin
					cell_op = OP_INSERT;
				end
			end
			S_COMPACT: begin
				if (more) begin
					cell_op = OP_COMPACT;
				end
			end
			S_IDLE, S_RESP: cell_op = OP_HOLD;
			default: cell_op = OP_HOLD;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_axis_tvalid) begin
			kind_q <= s_axis_tuser;
			lo_q   <= s_axis_tdata[31:0];
			hi_q   <= s_axis_tdata[63:32];
			pt_q   <= s_axis_tdata[95:64];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			found_q  <= 1'b0;
			status_q <= STAT_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: state_q <= S_ACT;
				S_ACT: begin
					found_q  <= 1'b0;
					status_q <= STAT_OK;
					state_q  <= S_RESP;
					if (kind_q == KIND_ADD) begin
						if (!add_ok) begin
							status_q <= STAT_REVERSED;
						end else if (any_join) begin
							state_q <= S_COMPACT;
						end else if (full) begin
							status_q <= STAT_FULL;
						end else begin
							count_q <= count_q + CNT_W'(1);
						end
					end else if (kind_q == KIND_QUERY) begin
						found_q <= any_hit;
					end else if (kind_q == KIND_CLEAR) begin
						count_q <= '0;
					end
				end
				S_COMPACT: begin
					// one absorbed entry leaves the row per cycle
					if (more) begin
						count_q <= count_q - CNT_W'(1);
					end else begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_RESP && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RESP && out_free) begin
			out_data_q <= {6'd0, count_q, status_q, found_q};
		end
	end

	assign s_axis_tready = state_q == S_IDLE;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_INTERVALS))
		else $error("interval count beyond capacity");

	a_compact_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMPACT && more) |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("compaction shift did not drop one entry");

	a_resp_only: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == S_RESP))
		else $error("result loaded outside the response step");

	a_merge_has_join: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMPACT) |-> any_join)
		else $error("compaction without a joined entry");
`endif

endmodule

// ----- tb/sorted_interval_set_top_tb.sv -----
`timescale 1ns / 1ps
// sorted_interval_set_top_tb: streams add, query, clear and stray items into the interval set
// and checks each result against an in-bench interval list; needs sis_pkg and the top level
module sorted_interval_set_top_tb;
	import sis_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int QUIET_LIMIT  = 5000;
	localparam int LONG_HOLD    = 400;
	localparam int DRAIN_CYCLES = 100;
	localparam int ITEM_TARGET  = 600;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] lower;
		logic [31:0] upper;
		logic [31:0] point;
	} span_req_t;

	typedef struct packed {
		logic             found;
		logic [1:0]       status;
		logic [CNT_W-1:0] count;
	} span_reply_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [95:0]  s_axis_tdata = '0;  // lower[31:0], upper[63:32], point[95:64]
	logic [1:0]   s_axis_tuser = '0;  // kind[1:0]
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [15:0]  m_axis_tdata;       // found[0], status[2:1], interval_count[9:3]

	// in-bench copy of the interval list
	logic [31:0] span_lo [MAX_INTERVALS];
	logic [31:0] span_hi [MAX_INTERVALS];
	int          span_cnt = 0;

	span_req_t   pending_reqs [$];
	span_reply_t replies_due [$];
	span_req_t   offered;
	int          useful_reqs = 0;
	int          gap_left = 0;
	int          stall_left = 0;
	bit          send_calm = 1'b0;
	bit          recv_calm = 1'b0;
	int          replies_seen = 0;
	int          fail_count = 0;
	int          quiet_cycles = 0;

	sorted_interval_set_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #10 clk = ~clk;

	// overlap or adjacency, without wrapping at the ends of the range
	function automatic bit touches(int k, logic [31:0] lo, logic [31:0] hi);
		logic [31:0] sl, sh;
		sl = span_lo[k];
		sh = span_hi[k];
		return (sl <= hi && lo <= sh) || (sh != 32'hFFFFFFFF && lo == sh + 32'd1) ||
			(sl != 32'd0 && hi == sl - 32'd1);
	endfunction

	function automatic logic [1:0] add_span(logic [31:0] lo, logic [31:0] hi);
		int i, k, n;
		n = span_cnt;
		if (lo > hi)
			return STAT_REVERSED;
		for (i = 0; i < n; i++) begin
			if (touches(i, lo, hi)) begin
				k = i;
				while (k == i || (k < n && touches(k, lo, hi))) begin
					if (span_lo[k] < lo)
						lo = span_lo[k];
					if (span_hi[k] > hi)
						hi = span_hi[k];
					k++;
				end
				span_lo[i] = lo;
				span_hi[i] = hi;
				i++;
				while (k < n) begin
					span_lo[i] = span_lo[k];
					span_hi[i] = span_hi[k];
					i++;
					k++;
				end
				span_cnt = i;
				return STAT_OK;
			end
			if (hi < span_lo[i])
				break;
		end
		if (n >= MAX_INTERVALS)
			return STAT_FULL;
		for (k = n; k > i; k--) begin
			span_lo[k] = span_lo[k - 1];
			span_hi[k] = span_hi[k - 1];
		end
		span_lo[i] = lo;
		span_hi[i] = hi;
		span_cnt = n + 1;
		return STAT_OK;
	endfunction

	function automatic logic point_in_set(logic [31:0] p);
		int i;
		for (i = 0; i < span_cnt; i++) begin
			if (span_hi[i] >= p)
				return span_lo[i] <= p;
		end
		return 1'b0;
	endfunction

	task automatic apply_item(input span_req_t r);
		span_reply_t rep;
		rep = '0;
		case (r.kind)
			KIND_ADD:   rep.status = add_span(r.lower, r.upper);
			KIND_QUERY: rep.found  = point_in_set(r.point);
			KIND_CLEAR: span_cnt   = 0;
			default: ;
		endcase
		rep.count = CNT_W'(span_cnt);
		replies_due.push_back(rep);
	endtask

	function automatic logic [31:0] clip32(longint v);
		if (v > 64'sd4294967295)
			return 32'hFFFFFFFF;
		return v[31:0];
	endfunction

	task automatic push_req(logic [1:0] kind, logic [31:0] lower, logic [31:0] upper,
			logic [31:0] point);
		span_req_t r;
		r.kind  = kind;
		r.lower = lower;
		r.upper = upper;
		r.point = point;
		pending_reqs.push_back(r);
		if (kind != KIND_UNUSED)
			useful_reqs++;
	endtask

	// adds and queries packed into one window so that merges happen often, with stray items and an optional clear
	task automatic window_run();
		longint      base;
		int unsigned span, reach;
		logic [31:0] lo, hi;
		int          r;
		case ($urandom_range(0, 3))
			0: span = 64;
			1: span = 1024;
			2: span = $urandom_range(16, 100000);
			default: span = 256;
		endcase
		reach = span / 8 + 1;
		case ($urandom_range(0, 3))
			0: base = 0;
			1: base = 64'sd4294967295 - span;
			default: base = $urandom;
		endcase
		repeat ($urandom_range(10, 40)) begin
			r  = $urandom_range(0, 99);
			lo = clip32(base + $urandom_range(0, span));
			hi = clip32(longint'(lo) + $urandom_range(0, reach));
			if (r < 55)
				push_req(KIND_ADD, lo, hi, $urandom);
			else if (r < 83)
				push_req(KIND_QUERY, $urandom, $urandom,
					clip32(base + $urandom_range(0, span + reach)));
			else if (r < 91)
				push_req(KIND_ADD, $urandom, $urandom, $urandom);  // reversed about half the time
			else if (r < 95)
				push_req(KIND_QUERY, $urandom, $urandom, $urandom);
			else if (r < 97)
				push_req(KIND_UNUSED, $urandom, $urandom, $urandom);
			else
				push_req(KIND_ADD, hi, lo, $urandom);
		end
		if ($urandom_range(0, 1))
			push_req(KIND_CLEAR, $urandom, $urandom, $urandom);
	endtask

	// more disjoint single-gap slots than the set holds, then merges while full
	task automatic fill_run();
		int          order [72];
		int          i, j, t, stride;
		longint      origin;
		logic [31:0] lo;
		stride = $urandom_range(2, 5);
		if ($urandom_range(0, 1))
			origin = $urandom_range(0, 32'hFFFF0000);
		else
			origin = 64'sd4294967295 - stride * 71;
		push_req(KIND_CLEAR, $urandom, $urandom, $urandom);
		for (i = 0; i < 72; i++)
			order[i] = i;
		for (i = 71; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		for (i = 0; i < 72; i++) begin
			lo = clip32(origin + stride * order[i]);
			push_req(KIND_ADD, lo, clip32(longint'(lo) + $urandom_range(0, stride - 2)), $urandom);
			if ($urandom_range(0, 3) == 0)
				push_req(KIND_QUERY, $urandom, $urandom,
					clip32(origin + $urandom_range(0, stride * 72)));
		end
		push_req(KIND_ADD, clip32(origin + 1), clip32(origin), $urandom);
		lo = clip32(origin + stride * $urandom_range(0, 60));
		push_req(KIND_ADD, lo, clip32(longint'(lo) + stride * 5), $urandom);
		push_req(KIND_QUERY, $urandom, $urandom, lo);
		// one add that swallows the whole list
		push_req(KIND_ADD, clip32(origin), clip32(origin + stride * 72), $urandom);
		push_req(KIND_QUERY, $urandom, $urandom, clip32(origin + stride * 40));
		push_req(KIND_CLEAR, $urandom, $urandom, $urandom);
	endtask

	always @(posedge clk or negedge arst_n) begin : driver
		logic take;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			gap_left      <= 0;
		end else begin
			take = 1'b0;
			if (s_axis_tvalid && s_axis_tready)
				apply_item(offered);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0)
					gap_left <= gap_left - 1;
				else if (pending_reqs.size() != 0)
					take = 1'b1;
			end
			if (take) begin
				offered = pending_reqs.pop_front();
				s_axis_tdata <= {offered.point, offered.upper, offered.lower};
				s_axis_tuser <= offered.kind;
				if ($urandom_range(0, 29) == 0)
					send_calm = !send_calm;
				gap_left <= send_calm ? 0 : $urandom_range(0, 8);
			end
			s_axis_tvalid <= take || (s_axis_tvalid && !s_axis_tready);
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		span_reply_t want;
		int          stall_next;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left    <= 0;
		end else begin
			stall_next = stall_left;
			if (m_axis_tvalid && m_axis_tready) begin
				if (replies_due.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $time,
						m_axis_tdata);
					fail_count++;
				end else begin
					want = replies_due.pop_front();
					if (m_axis_tdata[0] !== want.found) begin
						$display("%0t: found mismatch, expected %0d, actual %0d", $time,
							want.found, m_axis_tdata[0]);
						fail_count++;
					end
					if (m_axis_tdata[2:1] !== want.status) begin
						$display("%0t: status mismatch, expected %0d, actual %0d", $time,
							want.status, m_axis_tdata[2:1]);
						fail_count++;
					end
					if (m_axis_tdata[9:3] !== want.count) begin
						$display("%0t: count mismatch, expected %0d, actual %0d", $time,
							want.count, m_axis_tdata[9:3]);
						fail_count++;
					end
				end
				replies_seen++;
				// long hold so the block backs up and stalls its input
				if (replies_seen % 300 == 120)
					stall_next = LONG_HOLD;
				else begin
					if ($urandom_range(0, 29) == 0)
						recv_calm = !recv_calm;
					stall_next = recv_calm ? 0 : $urandom_range(0, 8);
				end
			end else if (stall_next > 0)
				stall_next--;
			stall_left    <= stall_next;
			m_axis_tready <= (stall_next == 0);
		end
	end

	always @(posedge clk) begin : watchdog
		if (arst_n && !(s_axis_tvalid && s_axis_tready) && !(m_axis_tvalid && m_axis_tready))
			quiet_cycles++;
		else
			quiet_cycles = 0;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("sorted_interval_set_top regression: fail");
			$finish;
		end
	end

	initial begin : sequencer
		int ep;
		// directed: empty set, reversed bounds, range ends, merges, stray kind, clear
		push_req(KIND_QUERY, 32'h0, 32'h0, 32'h0);
		push_req(KIND_ADD, 32'd5, 32'd4, 32'h0);
		push_req(KIND_ADD, 32'h0, 32'h0, 32'hFFFFFFFF);
		push_req(KIND_ADD, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0);
		push_req(KIND_QUERY, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0);
		push_req(KIND_QUERY, 32'h0, 32'h0, 32'hFFFFFFFF);
		push_req(KIND_QUERY, 32'h0, 32'h0, 32'd1);
		push_req(KIND_ADD, 32'd2, 32'd3, 32'h0);
		push_req(KIND_ADD, 32'd1, 32'd1, 32'h0);
		push_req(KIND_ADD, 32'd5, 32'd6, 32'h0);
		push_req(KIND_ADD, 32'd8, 32'd9, 32'h0);
		push_req(KIND_ADD, 32'd11, 32'd12, 32'h0);
		push_req(KIND_ADD, 32'd4, 32'd10, 32'h0);
		push_req(KIND_ADD, 32'hFFFFFFFE, 32'hFFFFFFFE, 32'h0);
		push_req(KIND_QUERY, 32'h0, 32'h0, 32'd12);
		push_req(KIND_QUERY, 32'h0, 32'h0, 32'd13);
		push_req(KIND_UNUSED, $urandom, $urandom, $urandom);
		push_req(KIND_ADD, 32'h0, 32'hFFFFFFFF, 32'h0);
		push_req(KIND_ADD, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF);
		push_req(KIND_CLEAR, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		push_req(KIND_QUERY, 32'h0, 32'h0, 32'hFFFFFFFF);
		push_req(KIND_ADD, 32'h80000000, 32'h80000000, 32'h80000000);
		ep = 0;
		while (useful_reqs < ITEM_TARGET) begin
			if (ep % 6 == 1)
				fill_run();
			else
				window_run();
			ep++;
		end

		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		while (pending_reqs.size() != 0 || s_axis_tvalid || replies_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && replies_due.size() == 0)
			$display("sorted_interval_set_top regression: pass");
		else
			$display("sorted_interval_set_top regression: fail");
		$finish;
	end

endmodule
